### rtl/tga_rle_image_decoder_defines.svh
// Assertion macros shared by the decoder RTL.
`ifndef TGA_RLE_IMAGE_DECODER_DEFINES_SVH
`define TGA_RLE_IMAGE_DECODER_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle or overlapping property on clk_i, off during reset.
`define TGA_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("tga decoder assertion failed");
// Condition on one edge, consequence on the next edge.
`define TGA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("tga decoder assertion failed");
`else
`define TGA_ASSERT(lbl, prop)
`define TGA_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

### rtl/tga_pkg.sv
// Types and constants for the TGA run-length image decoder.
`timescale 1ns / 1ps
`default_nettype none
package tga_pkg;

  typedef enum logic [2:0] {
    PH_HEADER,
    PH_IDSKIP,
    PH_HEAD,
    PH_PIXEL,
    PH_RAW,
    PH_DONE
  } phase_e;

  typedef enum logic [1:0] {
    ST_RUN    = 2'd0,
    ST_REJECT = 2'd1,
    ST_TRUNC  = 2'd2,
    ST_EMPTY  = 2'd3
  } status_e;

  typedef struct packed {
    status_e     status;
    logic [15:0] row;
    logic [15:0] column;
    logic [7:0]  run_length;
    logic [31:0] pixel;
    logic        image_last;
  } result_t;

  // write strobes into the output queue; second only together with first
  typedef struct packed {
    logic first;
    logic second;
  } push_t;

  localparam int unsigned FifoDepthDefault = 4;

  // header byte offsets
  localparam logic [4:0] HdrIdLen      = 5'd0;
  localparam logic [4:0] HdrCmapType   = 5'd1;
  localparam logic [4:0] HdrImgType    = 5'd2;
  localparam logic [4:0] HdrWidthLo    = 5'd12;
  localparam logic [4:0] HdrWidthHi    = 5'd13;
  localparam logic [4:0] HdrHeightLo   = 5'd14;
  localparam logic [4:0] HdrHeightHi   = 5'd15;
  localparam logic [4:0] HdrDepth      = 5'd16;
  localparam logic [4:0] HdrDescriptor = 5'd17;

  localparam logic [7:0] Depth24      = 8'd24;
  localparam logic [7:0] Depth32      = 8'd32;
  localparam logic [7:0] DescTopFirst = 8'h10;
  localparam logic [7:0] RleTypeLo    = 8'd9;
  localparam logic [7:0] RleTypeHi    = 8'd11;
  localparam logic [7:0] RepeatBias   = 8'd127;

endpackage
`default_nettype wire

### rtl/tga_rle_image_decoder.sv
// Top level of the TGA run-length image decoder.
//
// Usage:
//  s_axis carries the file one byte per word: tdata is the byte, tuser marks the
//  first byte of a file (restarts the parser), tlast marks the last byte that
//  the buffer holds. m_axis carries one result word per pixel run or event:
//  tuser is the status (run, header rejected, truncated, empty image), tlast
//  marks the word that completes the image.
//  Each byte is parsed combinationally as it is taken; its results are
//  written to a small registered queue that drives m_axis. A byte causes at
//  most two words (a run followed by a truncation).
//  Throughput is one byte per cycle; s_axis_tready drops only when the output
//  queue (FifoDepth words) has room for fewer than two words, so a stalled
//  receiver holds the input back after the queue fills and no word is lost.
//  Reset empties the queue and puts the parser at header byte 0; after a
//  rejection, truncation or finished image, bytes are dropped until the next
//  word with tuser set.
`timescale 1ns / 1ps
`default_nettype none
`include "tga_rle_image_decoder_defines.svh"
module tga_rle_image_decoder #(
  parameter int unsigned FifoDepth = tga_pkg::FifoDepthDefault
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] byte_value
  input  wire logic        s_axis_tuser,   // start_of_file
  input  wire logic        s_axis_tlast,   // end_of_buffer
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [71:0]      m_axis_tdata,   // [15:0] row, [31:16] column,
                                           // [39:32] run_length, [71:40] pixel
  output logic [1:0]       m_axis_tuser,   // status
  output logic             m_axis_tlast    // image_last
);

  function automatic tga_pkg::result_t mk_res(input tga_pkg::status_e st,
                                              input logic [15:0] r,
                                              input logic [15:0] c,
                                              input logic [7:0]  l,
                                              input logic [31:0] p,
                                              input logic        last);
    tga_pkg::result_t res;
    res.status     = st;
    res.row        = r;
    res.column     = c;
    res.run_length = l;
    res.pixel      = p;
    res.image_last = last;
    return res;
  endfunction

  tga_pkg::phase_e phase_q, phase_d, phase_cur;
  logic [4:0]  hbc_q, hbc_d;
  logic [7:0]  id_left_q, id_left_d;
  logic [7:0]  itype_q, itype_d;
  logic [15:0] width_q, width_d;
  logic [15:0] height_q, height_d;
  logic        four_q, four_d;
  logic        top_q, top_d;
  logic [15:0] row_q, row_d;
  logic [16:0] col_q, col_d;
  logic [7:0]  ppl_q, ppl_d;
  logic        rep_q, rep_d;
  logic [31:0] pa_q, pa_d;
  logic [1:0]  pbi_q, pbi_d;
  logic        bad_q, bad_d;

  logic             accept, active, start_data, pix_done, row_ok, last_run;
  logic             main_v, trunc_v;
  logic [16:0]      room, col_end, width_x;
  logic [7:0]       run_len;
  logic [15:0]      row_dest;
  tga_pkg::result_t res_main, res_trunc, fifo_d0, head;
  tga_pkg::push_t   push;
  logic             fifo_ready;

  assign accept  = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = fifo_ready;
  // width is only compared during pixel phases, where it holds the header value
  assign width_x = {1'b0, width_q};

  always_comb begin
    phase_d   = phase_q;
    hbc_d     = hbc_q;
    id_left_d = id_left_q;
    itype_d   = itype_q;
    width_d   = width_q;
    height_d  = height_q;
    four_d    = four_q;
    top_d     = top_q;
    row_d     = row_q;
    col_d     = col_q;
    ppl_d     = ppl_q;
    rep_d     = rep_q;
    pa_d      = pa_q;
    pbi_d     = pbi_q;
    bad_d     = bad_q;
    phase_cur = phase_q;
    main_v     = 1'b0;
    trunc_v    = 1'b0;
    start_data = 1'b0;
    pix_done   = 1'b0;
    room       = '0;
    run_len    = '0;
    col_end    = '0;
    last_run   = 1'b0;
    res_main   = '0;

    if (s_axis_tuser) begin
      phase_cur = tga_pkg::PH_HEADER;
      phase_d   = tga_pkg::PH_HEADER;
      hbc_d     = '0;
      id_left_d = '0;
      itype_d   = '0;
      width_d   = '0;
      height_d  = '0;
      four_d    = 1'b0;
      top_d     = 1'b0;
      row_d     = '0;
      col_d     = '0;
      ppl_d     = '0;
      rep_d     = 1'b0;
      pa_d      = '0;
      pbi_d     = '0;
      bad_d     = 1'b0;
    end
    active   = phase_cur != tga_pkg::PH_DONE;
    row_dest = top_d ? row_d : (height_d - 16'd1 - row_d);
    row_ok   = ({1'b0, row_d} + 17'd1) >= {1'b0, height_d};

    case (phase_cur)
      tga_pkg::PH_HEADER: begin
        case (hbc_d)
          tga_pkg::HdrIdLen:      id_left_d = s_axis_tdata;
          tga_pkg::HdrCmapType:   if (s_axis_tdata != 8'd0) bad_d = 1'b1;
          tga_pkg::HdrImgType:    itype_d = s_axis_tdata;
          tga_pkg::HdrWidthLo:    width_d[7:0] = s_axis_tdata;
          tga_pkg::HdrWidthHi:    width_d[15:8] = s_axis_tdata;
          tga_pkg::HdrHeightLo:   height_d[7:0] = s_axis_tdata;
          tga_pkg::HdrHeightHi:   height_d[15:8] = s_axis_tdata;
          tga_pkg::HdrDepth: begin
            if (s_axis_tdata == tga_pkg::Depth32) begin
              four_d = 1'b1;
            end else if (s_axis_tdata == tga_pkg::Depth24) begin
              four_d = 1'b0;
            end else begin
              bad_d = 1'b1;
            end
          end
          tga_pkg::HdrDescriptor: top_d = (s_axis_tdata & tga_pkg::DescTopFirst) != 8'd0;
          default: ;
        endcase
        if (hbc_d >= tga_pkg::HdrDescriptor) begin
          if (bad_d) begin
            main_v   = 1'b1;
            res_main = mk_res(tga_pkg::ST_REJECT, '0, '0, '0, '0, 1'b0);
            phase_d  = tga_pkg::PH_DONE;
          end else if (id_left_d != 8'd0) begin
            phase_d = tga_pkg::PH_IDSKIP;
          end else begin
            start_data = 1'b1;
          end
        end else begin
          hbc_d = hbc_d + 5'd1;
        end
      end

      tga_pkg::PH_IDSKIP: begin
        id_left_d = id_left_d - 8'd1;
        if (id_left_d == 8'd0) start_data = 1'b1;
      end

      tga_pkg::PH_HEAD: begin
        rep_d   = s_axis_tdata[7];
        ppl_d   = s_axis_tdata[7] ? (s_axis_tdata - tga_pkg::RepeatBias)
                                  : (s_axis_tdata + 8'd1);
        pa_d    = '0;
        pbi_d   = '0;
        phase_d = tga_pkg::PH_PIXEL;
      end

      tga_pkg::PH_PIXEL, tga_pkg::PH_RAW: begin
        pa_d = pa_d | ({24'd0, s_axis_tdata} << {pbi_d, 3'b000});
        if (pbi_d >= (four_d ? 2'd3 : 2'd2)) begin
          pbi_d    = '0;
          pix_done = 1'b1;
        end else begin
          pbi_d = pbi_d + 2'd1;
        end

        if (pix_done && phase_cur == tga_pkg::PH_RAW) begin
          last_run = ((col_d + 17'd1) >= width_x) && row_ok;
          main_v   = 1'b1;
          res_main = mk_res(tga_pkg::ST_RUN, row_d, col_d[15:0], 8'd1, pa_d, last_run);
          pa_d     = '0;
          if (last_run) begin
            phase_d = tga_pkg::PH_DONE;
          end else begin
            col_d = col_d + 17'd1;
            if (col_d >= width_x) begin
              row_d = row_d + 16'd1;
              col_d = '0;
            end
          end
        end else if (pix_done && rep_d) begin
          room     = width_x - col_d;
          run_len  = ({9'd0, ppl_d} > room) ? room[7:0] : ppl_d;
          col_end  = col_d + {9'd0, run_len};
          last_run = (col_end >= width_x) && row_ok;
          main_v   = 1'b1;
          res_main = mk_res(tga_pkg::ST_RUN, row_dest, col_d[15:0], run_len, pa_d,
                            last_run);
          col_d    = col_end;
          if (last_run) begin
            phase_d = tga_pkg::PH_DONE;
          end else begin
            if (col_end >= width_x) begin
              row_d = row_d + 16'd1;
              col_d = '0;
            end
            phase_d = tga_pkg::PH_HEAD;
          end
        end else if (pix_done) begin
          // literal pixels past the row end are consumed silently
          last_run = ((col_d + 17'd1) == width_x) && row_ok;
          if (col_d < width_x) begin
            main_v   = 1'b1;
            res_main = mk_res(tga_pkg::ST_RUN, row_dest, col_d[15:0], 8'd1, pa_d,
                              last_run);
          end
          if ((col_d < width_x) && last_run) begin
            phase_d = tga_pkg::PH_DONE;
          end else begin
            col_d = col_d + 17'd1;
            ppl_d = ppl_d - 8'd1;
            pa_d  = '0;
            if (ppl_d == 8'd0) begin
              if (col_d >= width_x) begin
                row_d = row_d + 16'd1;
                col_d = '0;
              end
              phase_d = tga_pkg::PH_HEAD;
            end
          end
        end
      end

      default: ;
    endcase

    if (start_data) begin
      row_d = '0;
      col_d = '0;
      pa_d  = '0;
      pbi_d = '0;
      if (width_d == 16'd0 || height_d == 16'd0) begin
        main_v   = 1'b1;
        res_main = mk_res(tga_pkg::ST_EMPTY, '0, '0, '0, '0, 1'b1);
        phase_d  = tga_pkg::PH_DONE;
      end else if (itype_d inside {[tga_pkg::RleTypeLo:tga_pkg::RleTypeHi]}) begin
        phase_d = tga_pkg::PH_HEAD;
      end else begin
        phase_d = tga_pkg::PH_RAW;
      end
    end

    if (s_axis_tlast && active && phase_d != tga_pkg::PH_DONE) begin
      trunc_v = 1'b1;
      phase_d = tga_pkg::PH_DONE;
    end
  end

  assign res_trunc   = mk_res(tga_pkg::ST_TRUNC, '0, '0, '0, '0, 1'b0);
  assign push.first  = accept && (main_v || trunc_v);
  assign push.second = accept && main_v && trunc_v;
  assign fifo_d0     = main_v ? res_main : res_trunc;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= tga_pkg::PH_HEADER;
      hbc_q     <= '0;
      id_left_q <= '0;
      itype_q   <= '0;
      width_q   <= '0;
      height_q  <= '0;
      four_q    <= 1'b0;
      top_q     <= 1'b0;
      row_q     <= '0;
      col_q     <= '0;
      ppl_q     <= '0;
      rep_q     <= 1'b0;
      pa_q      <= '0;
      pbi_q     <= '0;
      bad_q     <= 1'b0;
    end else if (accept) begin
      phase_q   <= phase_d;
      hbc_q     <= hbc_d;
      id_left_q <= id_left_d;
      itype_q   <= itype_d;
      width_q   <= width_d;
      height_q  <= height_d;
      four_q    <= four_d;
      top_q     <= top_d;
      row_q     <= row_d;
      col_q     <= col_d;
      ppl_q     <= ppl_d;
      rep_q     <= rep_d;
      pa_q      <= pa_d;
      pbi_q     <= pbi_d;
      bad_q     <= bad_d;
    end
  end

  tga_out_fifo #(
    .Depth(FifoDepth)
  ) u_out_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data0_i (fifo_d0),
    .data1_i (res_trunc),
    .ready_o (fifo_ready),
    .valid_o (m_axis_tvalid),
    .data_o  (head),
    .pop_i   (m_axis_tready)
  );

  assign m_axis_tdata = {head.pixel, head.run_length, head.column, head.row};
  assign m_axis_tuser = head.status;
  assign m_axis_tlast = head.image_last;

  `TGA_ASSERT(a_trunc_needs_last, trunc_v |-> s_axis_tlast)
  `TGA_ASSERT(a_done_is_quiet, (phase_q == tga_pkg::PH_DONE && !s_axis_tuser) |-> (!main_v && !trunc_v))
  `TGA_ASSERT_NEXT(a_last_ends_image, accept && main_v && res_main.image_last, phase_q == tga_pkg::PH_DONE)
  `TGA_ASSERT(a_run_len_nonzero, (main_v && res_main.status == tga_pkg::ST_RUN) |-> (res_main.run_length != 8'd0))

endmodule
`default_nettype wire

### rtl/tga_out_fifo.sv
// Result queue taking up to two words per cycle and giving one.
`timescale 1ns / 1ps
`default_nettype none
`include "tga_rle_image_decoder_defines.svh"
module tga_out_fifo #(
  parameter int unsigned Depth = tga_pkg::FifoDepthDefault  // power of two, >= 4
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire tga_pkg::push_t   push_i,
  input  wire tga_pkg::result_t data0_i,
  input  wire tga_pkg::result_t data1_i,
  output logic                  ready_o,   // room for two words
  output logic                  valid_o,
  output tga_pkg::result_t      data_o,
  input  wire logic             pop_i
);

  localparam int unsigned AddrW = $clog2(Depth);
  localparam logic [AddrW:0] DepthCnt = (AddrW + 1)'(Depth);

  tga_pkg::result_t mem_q [Depth];
  logic [AddrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [AddrW:0]   count_q, count_d;
  logic [1:0]       n_push;
  logic             pop;

  assign n_push  = {1'b0, push_i.first} + {1'b0, push_i.second};
  assign pop     = pop_i && (count_q != '0);
  assign wr_d    = wr_q + AddrW'(n_push);
  assign rd_d    = rd_q + AddrW'(pop);
  assign count_d = count_q + (AddrW + 1)'(n_push) - (AddrW + 1)'(pop);

  assign ready_o = count_q <= (DepthCnt - (AddrW + 1)'(2));
  assign valid_o = count_q != '0;
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i.first) begin
      mem_q[wr_q] <= data0_i;
    end
    if (push_i.second) begin
      mem_q[wr_q + AddrW'(1)] <= data1_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      count_q <= '0;
    end else begin
      wr_q    <= wr_d;
      rd_q    <= rd_d;
      count_q <= count_d;
    end
  end

  `TGA_ASSERT(a_push_order, push_i.second |-> push_i.first)
  `TGA_ASSERT(a_no_overflow, push_i.first |-> (count_q <= DepthCnt - (AddrW + 1)'(n_push)))
  `TGA_ASSERT_NEXT(a_valid_after_push, push_i.first, valid_o)

endmodule
`default_nettype wire

### tb/sv/tb_tga_rle_image_decoder.sv
// Self-checking testbench for the TGA run-length image decoder: byte stream in, run words out.
`timescale 1ns / 1ps
module tb_tga_rle_image_decoder;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'd0;
  logic        s_axis_tuser = 1'b0;
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [71:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        m_axis_tlast;

  tga_rle_image_decoder u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #5 clk_i = ~clk_i;

  tga_pkg::result_t expected_runs[$];
  logic [7:0]       file_bytes[$];
  int               fail_count = 0;
  bit               send_idle = 1'b1;
  bit               recv_stall = 1'b1;
  int               recv_hold = 0;
  int               stall_left = 0;

  // parser copy
  tga_pkg::phase_e prs_phase;
  logic [4:0]  hdr_idx;
  logic [7:0]  id_left;
  logic [7:0]  img_type;
  logic [15:0] img_w;
  logic [15:0] img_h;
  logic        px4;
  logic        top_first;
  logic [15:0] scan_row;
  logic [16:0] col_cnt;
  logic [7:0]  pkt_left;
  logic        pkt_rep;
  logic [31:0] px_acc;
  logic [1:0]  px_idx;
  logic        hdr_bad;

  function automatic void parser_reset();
    prs_phase = tga_pkg::PH_HEADER;
    hdr_idx   = '0;
    id_left   = '0;
    img_type  = '0;
    img_w     = '0;
    img_h     = '0;
    px4       = 1'b0;
    top_first = 1'b0;
    scan_row  = '0;
    col_cnt   = '0;
    pkt_left  = '0;
    pkt_rep   = 1'b0;
    px_acc    = '0;
    px_idx    = '0;
    hdr_bad   = 1'b0;
  endfunction

  function automatic void add_run(tga_pkg::status_e st, logic [15:0] row, logic [15:0] col,
                                  logic [7:0] len, logic [31:0] pix, logic fin);
    tga_pkg::result_t r;
    r.status     = st;
    r.row        = row;
    r.column     = col;
    r.run_length = len;
    r.pixel      = pix;
    r.image_last = fin;
    expected_runs.push_back(r);
  endfunction

  function automatic void start_image_data();
    scan_row = '0;
    col_cnt  = '0;
    px_acc   = '0;
    px_idx   = '0;
    if (img_w == 16'd0 || img_h == 16'd0) begin
      add_run(tga_pkg::ST_EMPTY, '0, '0, '0, '0, 1'b1);
      prs_phase = tga_pkg::PH_DONE;
    end else if (img_type >= tga_pkg::RleTypeLo && img_type <= tga_pkg::RleTypeHi) begin
      prs_phase = tga_pkg::PH_HEAD;
    end else begin
      prs_phase = tga_pkg::PH_RAW;
    end
  endfunction

  function automatic logic [15:0] out_row();
    logic [15:0] r;
    r = top_first ? scan_row : img_h - 16'd1 - scan_row;
    return r;
  endfunction

  function automatic void next_scanline();
    scan_row = scan_row + 16'd1;
    col_cnt  = '0;
  endfunction

  function automatic bit grab_pixel_byte(logic [7:0] b);
    logic [1:0] top;
    top = px4 ? 2'd3 : 2'd2;
    px_acc = px_acc | ({24'd0, b} << {px_idx, 3'b000});
    if (px_idx >= top) begin
      px_idx = '0;
      return 1'b1;
    end
    px_idx = px_idx + 2'd1;
    return 1'b0;
  endfunction

  function automatic void decode_byte(logic [7:0] b, logic sof, logic eob);
    bit          active;
    bit          fin;
    logic [16:0] room;
    logic [16:0] len;
    logic        rows_done;
    if (sof) parser_reset();
    active = (prs_phase != tga_pkg::PH_DONE);
    rows_done = ({1'b0, scan_row} + 17'd1) >= {1'b0, img_h};
    case (prs_phase)
      tga_pkg::PH_HEADER: begin
        case (hdr_idx)
          tga_pkg::HdrIdLen:      id_left = b;
          tga_pkg::HdrCmapType:   if (b != 8'd0) hdr_bad = 1'b1;
          tga_pkg::HdrImgType:    img_type = b;
          tga_pkg::HdrWidthLo:    img_w[7:0] = b;
          tga_pkg::HdrWidthHi:    img_w[15:8] = b;
          tga_pkg::HdrHeightLo:   img_h[7:0] = b;
          tga_pkg::HdrHeightHi:   img_h[15:8] = b;
          tga_pkg::HdrDepth: begin
            if (b == tga_pkg::Depth32) px4 = 1'b1;
            else if (b == tga_pkg::Depth24) px4 = 1'b0;
            else hdr_bad = 1'b1;
          end
          tga_pkg::HdrDescriptor: top_first = (b & tga_pkg::DescTopFirst) != 8'd0;
          default: ;
        endcase
        if (hdr_idx >= tga_pkg::HdrDescriptor) begin
          if (hdr_bad) begin
            add_run(tga_pkg::ST_REJECT, '0, '0, '0, '0, 1'b0);
            prs_phase = tga_pkg::PH_DONE;
          end else if (id_left != 8'd0) begin
            prs_phase = tga_pkg::PH_IDSKIP;
          end else begin
            start_image_data();
          end
        end else begin
          hdr_idx = hdr_idx + 5'd1;
        end
      end
      tga_pkg::PH_IDSKIP: begin
        id_left = id_left - 8'd1;
        if (id_left == 8'd0) start_image_data();
      end
      tga_pkg::PH_HEAD: begin
        pkt_rep   = b[7];
        pkt_left  = pkt_rep ? b - tga_pkg::RepeatBias : b + 8'd1;
        px_acc    = '0;
        px_idx    = '0;
        prs_phase = tga_pkg::PH_PIXEL;
      end
      tga_pkg::PH_PIXEL: if (grab_pixel_byte(b)) begin
        if (pkt_rep) begin
          room = {1'b0, img_w} - col_cnt;
          len  = {9'd0, pkt_left};
          if (len > room) len = room;
          col_cnt = col_cnt + len;
          fin = (col_cnt >= {1'b0, img_w}) && rows_done;
          add_run(tga_pkg::ST_RUN, out_row(), 16'(col_cnt - len), 8'(len), px_acc, fin);
          if (fin) begin
            prs_phase = tga_pkg::PH_DONE;
          end else begin
            if (col_cnt >= {1'b0, img_w}) next_scanline();
            prs_phase = tga_pkg::PH_HEAD;
          end
        end else begin
          fin = 1'b0;
          if (col_cnt < {1'b0, img_w}) begin
            fin = (col_cnt + 17'd1 == {1'b0, img_w}) && rows_done;
            add_run(tga_pkg::ST_RUN, out_row(), col_cnt[15:0], 8'd1, px_acc, fin);
          end
          if (fin) begin
            prs_phase = tga_pkg::PH_DONE;
          end else begin
            col_cnt  = col_cnt + 17'd1;
            pkt_left = pkt_left - 8'd1;
            px_acc   = '0;
            if (pkt_left == 8'd0) begin
              if (col_cnt >= {1'b0, img_w}) next_scanline();
              prs_phase = tga_pkg::PH_HEAD;
            end
          end
        end
      end
      tga_pkg::PH_RAW: if (grab_pixel_byte(b)) begin
        fin = (col_cnt + 17'd1 >= {1'b0, img_w}) && rows_done;
        add_run(tga_pkg::ST_RUN, scan_row, col_cnt[15:0], 8'd1, px_acc, fin);
        px_acc = '0;
        if (fin) begin
          prs_phase = tga_pkg::PH_DONE;
        end else begin
          col_cnt = col_cnt + 17'd1;
          if (col_cnt >= {1'b0, img_w}) next_scanline();
        end
      end
      default: ;
    endcase
    if (eob && active && prs_phase != tga_pkg::PH_DONE) begin
      add_run(tga_pkg::ST_TRUNC, '0, '0, '0, '0, 1'b0);
      prs_phase = tga_pkg::PH_DONE;
    end
  endfunction

  // ---- output side ----
  function automatic void check_field(string what, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, what, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk_i) begin
    tga_pkg::result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_runs.size() == 0) begin
        $display("%0t: unexpected word, expected none actual status %0d tdata %0h last %0b",
                 $time, m_axis_tuser, m_axis_tdata, m_axis_tlast);
        fail_count++;
      end else begin
        want = expected_runs.pop_front();
        check_field("status", 32'(want.status), 32'(m_axis_tuser));
        check_field("row", 32'(want.row), 32'(m_axis_tdata[15:0]));
        check_field("column", 32'(want.column), 32'(m_axis_tdata[31:16]));
        check_field("run_length", 32'(want.run_length), 32'(m_axis_tdata[39:32]));
        check_field("pixel", want.pixel, m_axis_tdata[71:40]);
        check_field("image_last", 32'(want.image_last), 32'(m_axis_tlast));
      end
    end
  end

  initial begin
    forever begin
      @(posedge clk_i);
      if (recv_hold > 0) begin
        m_axis_tready <= 1'b0;
        recv_hold--;
      end else if (stall_left > 0) begin
        m_axis_tready <= 1'b0;
        stall_left--;
      end else if (recv_stall && $urandom_range(0, 5) == 0) begin
        m_axis_tready <= 1'b0;
        stall_left = $urandom_range(0, 4);
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // ---- input side ----
  task automatic send_byte(logic [7:0] b, logic sof, logic eob);
    int gap;
    if (send_idle && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 5);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tuser  <= sof;
    s_axis_tlast  <= eob;
    do @(posedge clk_i); while (!s_axis_tready);
    decode_byte(b, sof, eob);
  endtask

  task automatic send_file(int count, bit sof_first, bit eob_last);
    for (int i = 0; i < count; i++)
      send_byte(file_bytes[i], sof_first && i == 0, eob_last && i == count - 1);
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (expected_runs.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  function automatic void put_header(logic [7:0] id_len, logic [7:0] cmap, logic [7:0] itype,
                                     logic [15:0] w, logic [15:0] h, logic [7:0] depth,
                                     logic [7:0] desc);
    file_bytes.delete();
    file_bytes.push_back(id_len);
    file_bytes.push_back(cmap);
    file_bytes.push_back(itype);
    repeat (9) file_bytes.push_back(8'($urandom_range(0, 255)));
    file_bytes.push_back(w[7:0]);
    file_bytes.push_back(w[15:8]);
    file_bytes.push_back(h[7:0]);
    file_bytes.push_back(h[15:8]);
    file_bytes.push_back(depth);
    file_bytes.push_back(desc);
    repeat (id_len) file_bytes.push_back(8'($urandom_range(0, 255)));
  endfunction

  function automatic void put_pixel(bit four);
    repeat (four ? 4 : 3) file_bytes.push_back(8'($urandom_range(0, 255)));
  endfunction

  // scanline-aligned packets, with some clipped repeats and overlong literals
  function automatic void put_rle_rows(int w, int h, bit four);
    int col;
    int n;
    int span;
    logic [7:0] head;
    for (int r = 0; r < h; r++) begin
      col = 0;
      while (col < w) begin
        span = w - col;
        if ($urandom_range(0, 1) == 1) begin
          n = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 128) : $urandom_range(1, span);
          if (n > 128) n = 128;
          head = 8'(127 + n);
          file_bytes.push_back(head);
          put_pixel(four);
        end else begin
          n = ($urandom_range(0, 7) == 0) ? span + $urandom_range(1, 3)
                                          : $urandom_range(1, span);
          if (n > 128) n = 128;
          head = 8'(n - 1);
          file_bytes.push_back(head);
          repeat (n) put_pixel(four);
        end
        col += n;
      end
    end
  endfunction

  // ---- tests ----
  task automatic test_after_reset();
    put_header(8'd0, 8'd0, 8'd2, 16'd1, 16'd1, tga_pkg::Depth24, 8'h00);
    put_pixel(1'b0);
    send_file(file_bytes.size(), 1'b0, 1'b1);
    wait_drained();
  endtask

  task automatic test_header_reject();
    put_header(8'd0, 8'd1, 8'd10, 16'd2, 16'd2, tga_pkg::Depth24, 8'h00);
    repeat (4) file_bytes.push_back(8'($urandom_range(0, 255)));
    send_file(file_bytes.size(), 1'b1, 1'b1);
    put_header(8'd1, 8'd0, 8'd2, 16'd1, 16'd1, 8'd16, 8'h00);
    send_file(file_bytes.size(), 1'b1, 1'b0);
    put_header(8'd0, 8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF);
    send_file(file_bytes.size(), 1'b1, 1'b1);
    put_header(8'd0, 8'd0, 8'd0, 16'd0, 16'd0, 8'd0, 8'd0);
    send_file(file_bytes.size(), 1'b1, 1'b1);
    wait_drained();
  endtask

  task automatic test_empty_image();
    put_header(8'd2, 8'd0, 8'd10, 16'd0, 16'd3, tga_pkg::Depth32, 8'h00);
    send_file(file_bytes.size(), 1'b1, 1'b1);
    put_header(8'd0, 8'd0, 8'd2, 16'hFF00, 16'd0, tga_pkg::Depth24, 8'h10);
    file_bytes.push_back(8'h55);
    send_file(file_bytes.size(), 1'b1, 1'b0);
    wait_drained();
  endtask

  task automatic test_rle_packets();
    // 4x3 bottom-up: clipped repeat, overlong literal, literal then repeat
    put_header(8'd0, 8'd0, 8'd10, 16'd4, 16'd3, tga_pkg::Depth24, 8'h00);
    file_bytes.push_back(8'h85);
    put_pixel(1'b0);
    file_bytes.push_back(8'h05);
    repeat (6) put_pixel(1'b0);
    file_bytes.push_back(8'h01);
    repeat (2) put_pixel(1'b0);
    file_bytes.push_back(8'h81);
    put_pixel(1'b0);
    file_bytes.push_back(8'h00);
    put_pixel(1'b0);
    send_file(file_bytes.size(), 1'b1, 1'b1);
    // top-down, 32-bit, longest literal cut short by image end
    put_header(8'd1, 8'd0, 8'd11, 16'd3, 16'd1, tga_pkg::Depth32, 8'h10);
    file_bytes.push_back(8'h7F);
    repeat (5) put_pixel(1'b1);
    send_file(file_bytes.size(), 1'b1, 1'b0);
    // longest repeat, all-ones and all-zero pixels
    put_header(8'd0, 8'd0, 8'd9, 16'd130, 16'd1, tga_pkg::Depth24, 8'hEF);
    file_bytes.push_back(8'hFF);
    repeat (3) file_bytes.push_back(8'hFF);
    file_bytes.push_back(8'h81);
    repeat (3) file_bytes.push_back(8'h00);
    send_file(file_bytes.size(), 1'b1, 1'b1);
    wait_drained();
  endtask

  task automatic test_raw_pixels();
    put_header(8'd0, 8'd0, 8'd2, 16'd3, 16'd2, tga_pkg::Depth32, 8'h10);
    repeat (6) put_pixel(1'b1);
    send_file(file_bytes.size(), 1'b1, 1'b1);
    put_header(8'd0, 8'd0, 8'd0, 16'd2, 16'd1, tga_pkg::Depth24, 8'h20);
    repeat (2) put_pixel(1'b0);
    send_file(file_bytes.size(), 1'b1, 1'b0);
    put_header(8'd0, 8'd0, 8'd12, 16'd1, 16'd2, tga_pkg::Depth24, 8'h00);
    repeat (2) put_pixel(1'b0);
    send_file(file_bytes.size(), 1'b1, 1'b1);
    put_header(8'd0, 8'd0, 8'd8, 16'd2, 16'd1, tga_pkg::Depth32, 8'h00);
    repeat (2) put_pixel(1'b1);
    send_file(file_bytes.size(), 1'b1, 1'b1);
    wait_drained();
  endtask

  task automatic test_truncation();
    put_header(8'd3, 8'd0, 8'd10, 16'd2, 16'd2, tga_pkg::Depth24, 8'h00);
    send_file(6, 1'b1, 1'b1);       // inside header
    send_file(1, 1'b1, 1'b1);       // first and last byte at once
    send_file(20, 1'b1, 1'b1);      // inside ID field
    put_header(8'd0, 8'd0, 8'd10, 16'd2, 16'd1, tga_pkg::Depth32, 8'h00);
    file_bytes.push_back(8'h81);
    put_pixel(1'b1);
    send_file(18, 1'b1, 1'b1);      // on last header byte
    send_file(19, 1'b1, 1'b1);      // on packet head
    send_file(21, 1'b1, 1'b1);      // mid pixel
    put_header(8'd0, 8'd0, 8'd2, 16'd2, 16'd1, tga_pkg::Depth24, 8'h00);
    repeat (2) put_pixel(1'b0);
    send_file(21, 1'b1, 1'b1);      // run then truncation
    put_header(8'd0, 8'd0, 8'd10, 16'd4, 16'd2, tga_pkg::Depth24, 8'h10);
    file_bytes.push_back(8'h81);
    put_pixel(1'b0);
    send_file(file_bytes.size(), 1'b1, 1'b1);
    wait_drained();
  endtask

  task automatic test_restart();
    put_header(8'd0, 8'd0, 8'd10, 16'd3, 16'd2, tga_pkg::Depth24, 8'h00);
    put_rle_rows(3, 2, 1'b0);
    send_file(file_bytes.size() - 4, 1'b1, 1'b0);
    put_header(8'd0, 8'd0, 8'd3, 16'd2, 16'd2, tga_pkg::Depth24, 8'h00);
    repeat (4) put_pixel(1'b0);
    send_file(file_bytes.size(), 1'b1, 1'b1);
    wait_drained();
  endtask

  task automatic test_backpressure();
    recv_hold = 300;
    put_header(8'd0, 8'd0, 8'd2, 16'd12, 16'd4, tga_pkg::Depth32, 8'h00);
    repeat (48) put_pixel(1'b1);
    send_file(file_bytes.size(), 1'b1, 1'b1);
    wait_drained();
  endtask

  task automatic test_random_files();
    int rand_bytes;
    int w;
    int h;
    int m;
    int count;
    logic [7:0] itype;
    logic [7:0] depth;
    logic [7:0] cmap;
    logic [7:0] id_len;
    bit four;
    rand_bytes = 0;
    while (rand_bytes < 750) begin
      if (rand_bytes > 600) begin
        send_idle  = 1'b0;
        recv_stall = 1'b0;
      end else begin
        send_idle  = $urandom_range(0, 3) != 0;
        recv_stall = $urandom_range(0, 3) != 0;
      end
      if ($urandom_range(0, 9) < 6) begin
        itype = 8'($urandom_range(9, 11));
      end else begin
        case ($urandom_range(0, 3))
          0: itype = 8'd2;
          1: itype = 8'd3;
          2: itype = 8'd12;
          default: itype = 8'($urandom_range(0, 255));
        endcase
      end
      w = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 12);
      h = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 4);
      if ($urandom_range(0, 24) == 0) begin
        w = $urandom_range(100, 140);
        h = 1;
      end
      depth  = ($urandom_range(0, 15) == 0) ? 8'($urandom_range(0, 255))
             : (($urandom_range(0, 1) == 1) ? tga_pkg::Depth32 : tga_pkg::Depth24);
      cmap   = ($urandom_range(0, 15) == 0) ? 8'($urandom_range(1, 255)) : 8'd0;
      id_len = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 40))
                                           : 8'($urandom_range(0, 2));
      four   = (depth == tga_pkg::Depth32);
      put_header(id_len, cmap, itype, 16'(w), 16'(h), depth, 8'($urandom_range(0, 255)));
      if (itype >= tga_pkg::RleTypeLo && itype <= tga_pkg::RleTypeHi) begin
        put_rle_rows(w, h, four);
      end else begin
        repeat (w * h) put_pixel(four);
      end
      count = file_bytes.size();
      m = $urandom_range(0, 9);
      case (m)
        0: send_file($urandom_range(1, count), 1'b1, 1'b1);
        1: begin
          file_bytes[$urandom_range(0, count - 1)] = 8'($urandom_range(0, 255));
          send_file(count, 1'b1, 1'b1);
        end
        2: begin
          repeat ($urandom_range(1, 4)) file_bytes.push_back(8'($urandom_range(0, 255)));
          send_file(file_bytes.size(), 1'b1, $urandom_range(0, 1) == 1);
        end
        3: send_file(count, 1'b1, 1'b0);
        4: send_file($urandom_range(1, count), 1'b1, 1'b0);
        default: send_file(count, 1'b1, 1'b1);
      endcase
      rand_bytes += file_bytes.size();
    end
    wait_drained();
  endtask

  initial begin
    parser_reset();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_after_reset();
    test_header_reject();
    test_empty_image();
    test_rle_packets();
    test_raw_pixels();
    test_truncation();
    test_restart();
    test_backpressure();
    test_random_files();
    repeat (20) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("tga_rle_image_decoder verification clean");
    end else begin
      $display("tga_rle_image_decoder verification failed");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("tga_rle_image_decoder verification failed");
    $finish;
  end

endmodule
